[rtl/core/adpk_pkg.sv]
// Shared types and constants for the ASCII date/time to DOS packed-word converter.
package adpk_pkg;

  // Record layout
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] LAST_POS = 5'd18;
  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  // Two-digit field arithmetic: value = hi*10 + lo - ('0'*10 + '0')
  localparam int unsigned SUM_W = 12;
  localparam int unsigned VAL_W = 13;
  localparam logic signed [VAL_W-1:0] DIGIT_BIAS = 13'sd528;
  localparam logic signed [VAL_W-1:0] YEAR_BASE = 13'sd80;

  // Range limits
  localparam logic signed [VAL_W-1:0] MONTH_MIN = 13'sd1;
  localparam logic signed [VAL_W-1:0] MONTH_MAX = 13'sd12;
  localparam logic signed [VAL_W-1:0] DAY_MIN = 13'sd1;
  localparam logic signed [VAL_W-1:0] DAY_MAX = 13'sd31;
  localparam logic signed [VAL_W-1:0] YEAR_OFF_MAX = 13'sd19;
  localparam logic signed [VAL_W-1:0] HOUR_MAX = 13'sd23;
  localparam logic signed [VAL_W-1:0] MIN_SEC_MAX = 13'sd59;
  localparam logic signed [VAL_W-1:0] VAL_ZERO = 13'sd0;

  // Queue depth default
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Work codes passed from the front end to the back end
  typedef enum logic [2:0] {
    OP_FIRST = 3'd0,
    OP_MONTH = 3'd1,
    OP_DAY   = 3'd2,
    OP_YEAR  = 3'd3,
    OP_HOUR  = 3'd4,
    OP_MIN   = 3'd5,
    OP_SEC   = 3'd6,
    OP_END   = 3'd7
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } entry_t;

endpackage

[rtl/core/adpk_front.sv]
// Front end: tracks record position; digit and last bytes become work entries.
module adpk_front
  import adpk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             accept;
  logic             skip;
  logic             need;
  op_t              op;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign skip     = (pos_r == '0) && (in_data_byte == CHAR_CR || in_data_byte == CHAR_LF);

  // Classify the byte by its position in the record
  always_comb begin
    need = 1'b1;
    op   = OP_FIRST;
    if (pos_r >= LAST_POS) begin
      op = OP_END;
    end else begin
      unique case (pos_r)
        5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15: op = OP_FIRST;
        5'd1:  op = OP_MONTH;
        5'd4:  op = OP_DAY;
        5'd7:  op = OP_YEAR;
        5'd10: op = OP_HOUR;
        5'd13: op = OP_MIN;
        5'd16: op = OP_SEC;
        default: need = 1'b0;
      endcase
    end
  end

  assign push            = accept && !skip && need;
  assign push_entry.op   = op;
  assign push_entry.data = in_data_byte;

  // Advance the position; wrap after the last byte
  always_comb begin
    pos_nxt = pos_r;
    if (accept && !skip) begin
      if (pos_r >= LAST_POS) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("record position beyond last byte");
  a_skip_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && skip) |=> (pos_r == '0))
    else $error("skipped line ending moved the position");
`endif

endmodule

[rtl/core/adpk_queue.sv]
// Short work queue that decouples the front end from the back end.
module adpk_queue
  import adpk_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue occupancy overflow");
  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not lower occupancy");
`endif

endmodule

[rtl/core/adpk_back.sv]
// Back end: evaluates digit pairs, range checks fields and packs the DOS words.
module adpk_back
  import adpk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  entry_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_fields_valid,
  output logic [15:0] out_time_word,
  output logic [15:0] out_date_word
);

  logic [7:0]  first_char_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  year_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic        range_err_r, range_err_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        fields_valid_r;
  logic [15:0] time_word_r;
  logic [15:0] date_word_r;

  logic                   is_end;
  logic                   slot_free;
  logic [SUM_W-1:0]       pair_sum;
  logic signed [VAL_W-1:0] val;
  logic signed [VAL_W-1:0] year_off;
  logic                   in_range;

  assign is_end    = (head.op == OP_END);
  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = q_not_empty && (!is_end || slot_free);

  // Digit pair value: hi*10 + lo, then remove the ASCII bias
  assign pair_sum = {1'b0, first_char_r, 3'b000} + {3'b000, first_char_r, 1'b0}
                  + {4'b0000, head.data};
  assign val      = $signed({1'b0, pair_sum}) - DIGIT_BIAS;
  assign year_off = val - YEAR_BASE;

  // Range check for the field at the head
  always_comb begin
    unique case (head.op)
      OP_MONTH: in_range = (val >= MONTH_MIN) && (val <= MONTH_MAX);
      OP_DAY:   in_range = (val >= DAY_MIN) && (val <= DAY_MAX);
      OP_YEAR:  in_range = (year_off >= VAL_ZERO) && (year_off <= YEAR_OFF_MAX);
      OP_HOUR:  in_range = (val >= VAL_ZERO) && (val <= HOUR_MAX);
      OP_MIN,
      OP_SEC:   in_range = (val >= VAL_ZERO) && (val <= MIN_SEC_MAX);
      default:  in_range = 1'b1;
    endcase
  end

  // Store in-range field values; no reset, as a failed record packs zeros
  always_ff @(posedge clk) begin
    if (pop) begin
      unique case (head.op)
        OP_FIRST: first_char_r <= head.data;
        OP_MONTH: if (in_range) month_r <= val[3:0];
        OP_DAY:   if (in_range) day_r   <= val[4:0];
        OP_YEAR:  if (in_range) year_r  <= year_off[4:0];
        OP_HOUR:  if (in_range) hour_r  <= val[4:0];
        OP_MIN:   if (in_range) min_r   <= val[5:0];
        OP_SEC:   if (in_range) sec_r   <= val[5:0];
        default: ;
      endcase
    end
  end

  // Error flag and output handshake
  always_comb begin
    range_err_nxt = range_err_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      if (is_end) begin
        range_err_nxt = 1'b0;
        out_valid_nxt = 1'b1;
      end else if (!in_range) begin
        range_err_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_err_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      range_err_r <= range_err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pack the result words at end of record
  always_ff @(posedge clk) begin
    if (pop && is_end) begin
      fields_valid_r <= !range_err_r;
      if (range_err_r) begin
        time_word_r <= '0;
        date_word_r <= '0;
      end else begin
        time_word_r <= {hour_r, min_r, sec_r[5:1]};
        date_word_r <= {2'b00, year_r, month_r, day_r};
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fields_valid = fields_valid_r;
  assign out_time_word    = time_word_r;
  assign out_date_word    = date_word_r;

`ifndef ASSERT_OFF
  a_end_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && is_end) |=> out_valid_r)
    else $error("end of record produced no word");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && is_end) |=> !range_err_r)
    else $error("range error survived end of record");
`endif

endmodule

[rtl/core/ascii_datetime_to_dos_packed_unit.sv]
// Top level: ASCII "MM/DD/YY hh:mm:ss" CR LF record to packed DOS time and date words.
//
// Input channel: one ASCII byte per word on in_data_byte, taken when in_valid
// is high and in_stall is low. A CR or LF at the start of a record is dropped.
// Each 19-byte record yields one output word: out_fields_valid, out_time_word
// (hour<<11 | minute<<5 | second>>1) and out_date_word
// ((year-80)<<9 | month<<5 | day); both words are zero when any field fails
// its range check. Separator bytes are counted but never checked.
// Throughput: one byte per cycle while in_stall is low. The front end classifies
// bytes by record position and feeds a short queue; the back end drains one
// entry per cycle, unless the end-of-record entry waits for the receiver,
// through a constant multiply-add and range compare. The result is registered:
// the last byte's entry passes through the queue, and out_valid is set when it is popped.
// When the receiver stalls, the result is held in the output register; only
// the end-of-record entry waits, and in_stall rises once the queue fills.
// Reset (rst_n low, synchronous) returns to record position zero with an
// empty queue and no pending result.
module ascii_datetime_to_dos_packed_unit
  import adpk_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_fields_valid,
  output logic [15:0] out_time_word,
  output logic [15:0] out_date_word
);

  logic   q_full;
  logic   q_not_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;

  adpk_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  adpk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  adpk_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fields_valid (out_fields_valid),
    .out_time_word    (out_time_word),
    .out_date_word    (out_date_word)
  );

endmodule

[tb/testbench.sv]
// Testbench for the ASCII date/time record to packed DOS time/date word converter.
module testbench;
  import adpk_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CHARS = 1500;
  localparam int IDLE_PCT = 27;

  typedef struct {
    logic [7:0] ch;
    bit         wait_drain;
  } char_word_t;

  typedef struct {
    logic        ok;
    logic [15:0] time_word;
    logic [15:0] date_word;
  } dos_stamp_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_fields_valid;
  logic [15:0] out_time_word;
  logic [15:0] out_date_word;

  char_word_t chars_to_send[$];
  dos_stamp_t stamps_due[$];
  logic [7:0] draft[$];

  // Predictor copy of the record parser state
  logic [4:0] rec_pos = '0;
  logic [7:0] lead_char = '0;
  logic [3:0] month_q = '0;
  logic [4:0] day_q = '0;
  logic [4:0] year_q = '0;
  logic [4:0] hour_q = '0;
  logic [5:0] minute_q = '0;
  logic [5:0] second_q = '0;
  logic       bad_field = 1'b0;

  logic in_taken = 1'b0;
  int   words_in = 0;
  int   total_chars = 0;
  int   stamps_checked = 0;
  int   stamps_valid = 0;
  int   mismatch_count = 0;
  logic steady;

  // No idling on either side through the middle of the random part
  assign steady = (words_in >= 700) && (words_in < 1000);

  ascii_datetime_to_dos_packed_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fields_valid (out_fields_valid),
    .out_time_word    (out_time_word),
    .out_date_word    (out_date_word)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= 60)
      $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want,
               stamps_checked);
  endtask

  // Advance the parser by one accepted character; queue a stamp at end of record
  function automatic void pack_record_char(logic [7:0] ch);
    int pair;
    dos_stamp_t s;
    if (rec_pos == 5'd0 && (ch == CHAR_CR || ch == CHAR_LF)) return;
    if (rec_pos >= LAST_POS) begin
      s.ok = !bad_field;
      s.time_word = bad_field ? 16'd0 : {hour_q, minute_q, second_q[5:1]};
      s.date_word = bad_field ? 16'd0 : {2'b00, year_q, month_q, day_q};
      stamps_due.push_back(s);
      rec_pos = '0;
      bad_field = 1'b0;
      return;
    end
    pair = (int'(lead_char) - 48) * 10 + (int'(ch) - 48);
    case (rec_pos)
      0, 3, 6, 9, 12, 15: lead_char = ch;
      1:  if (pair >= 1 && pair <= 12) month_q = 4'(pair); else bad_field = 1'b1;
      4:  if (pair >= 1 && pair <= 31) day_q = 5'(pair); else bad_field = 1'b1;
      7:  if (pair >= 80 && pair <= 99) year_q = 5'(pair - 80); else bad_field = 1'b1;
      10: if (pair >= 0 && pair <= 23) hour_q = 5'(pair); else bad_field = 1'b1;
      13: if (pair >= 0 && pair <= 59) minute_q = 6'(pair); else bad_field = 1'b1;
      16: if (pair >= 0 && pair <= 59) second_q = 6'(pair); else bad_field = 1'b1;
      default: ;
    endcase
    rec_pos = rec_pos + 5'd1;
  endfunction

  function automatic void add_char(logic [7:0] ch, bit wait_drain = 1'b0);
    char_word_t w;
    w.ch = ch;
    w.wait_drain = wait_drain;
    chars_to_send.push_back(w);
  endfunction

  // Queue a 17-character body followed by CR LF
  function automatic void add_record(string body, bit wait_drain = 1'b0);
    for (int i = 0; i < body.len(); i++) add_char(body[i], wait_drain && i == 0);
    add_char(CHAR_CR);
    add_char(CHAR_LF);
  endfunction

  // Append a two-character field: mostly in range, sometimes any pair or raw bytes
  function automatic void draft_field(int lo, int hi);
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 90) begin
      v = (pick < 75) ? $urandom_range(hi, lo) : $urandom_range(99, 0);
      draft.push_back(8'(48 + v / 10));
      draft.push_back(8'(48 + v % 10));
    end else begin
      draft.push_back(8'($urandom_range(255, 0)));
      draft.push_back(8'($urandom_range(255, 0)));
    end
  endfunction

  function automatic void draft_sep(logic [7:0] ch);
    draft.push_back(($urandom_range(99) < 88) ? ch : 8'($urandom_range(255, 0)));
  endfunction

  // Driver: hold a stalled word, otherwise present the next one or idle
  always @(negedge clk) begin
    logic [7:0] nxt_ch;
    logic       nxt_valid;
    char_word_t nxt_w;
    nxt_ch = in_data_byte;
    nxt_valid = in_valid;
    if (rst_n && (!in_valid || in_taken)) begin
      nxt_valid = 1'b0;
      if (chars_to_send.size() != 0 &&
          !(chars_to_send[0].wait_drain && stamps_due.size() != 0) &&
          (steady || $urandom_range(99) >= IDLE_PCT)) begin
        nxt_valid = 1'b1;
        nxt_w = chars_to_send.pop_front();
        nxt_ch = nxt_w.ch;
      end
    end
    in_valid <= nxt_valid;
    in_data_byte <= nxt_ch;
  end

  // Receiver: stall at random outside the steady stretch
  always @(negedge clk) begin
    out_stall <= rst_n && !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // Monitor: check results against the oldest stamp, then predict from the input word
  always @(posedge clk) begin
    dos_stamp_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (stamps_due.size() == 0) begin
        flag_mismatch("result with none expected", out_time_word, 16'd0);
      end else begin
        want = stamps_due.pop_front();
        if (out_fields_valid !== want.ok)
          flag_mismatch("fields_valid", 16'(out_fields_valid), 16'(want.ok));
        if (out_time_word !== want.time_word)
          flag_mismatch("time_word", out_time_word, want.time_word);
        if (out_date_word !== want.date_word)
          flag_mismatch("date_word", out_date_word, want.date_word);
        stamps_checked++;
        if (want.ok) stamps_valid++;
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      pack_record_char(in_data_byte);
      words_in++;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int pick;
    int keep;
    int rec_no;

    // Directed: skipped CR LF, field extremes, non-digit pairs, raw byte records
    add_char(CHAR_CR);
    add_char(CHAR_LF);
    add_record("01/01/80 00:00:00");
    add_record("12/31/99 23:59:59");
    add_record("13/32/79 24:60:60");
    add_record("00/00/00 00:00:01");
    add_record("0:/1?/8: 1:/4:/4?");
    add_record("/9/31/99 23:59:58");
    for (int i = 0; i < 19; i++) add_char(8'hff);
    add_record("12/31/99 23:59:59", 1'b1);
    for (int i = 0; i < 19; i++) add_char(8'h00);
    add_record("06/15/91 12:30:45");

    // Random: mostly well-formed records, some noise and truncated records
    rec_no = 0;
    while (chars_to_send.size() < RANDOM_CHARS) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(6, 1)) add_char(8'($urandom_range(255, 0)));
      end else begin
        draft.delete();
        if ($urandom_range(99) < 30)
          repeat ($urandom_range(2, 1))
            draft.push_back(($urandom_range(1) != 0) ? CHAR_CR : CHAR_LF);
        draft_field(1, 12);
        draft_sep("/");
        draft_field(1, 31);
        draft_sep("/");
        draft_field(80, 99);
        draft_sep(" ");
        draft_field(0, 23);
        draft_sep(":");
        draft_field(0, 59);
        draft_sep(":");
        draft_field(0, 59);
        draft_sep(CHAR_CR);
        draft_sep(CHAR_LF);
        keep = (pick < 15) ? $urandom_range(draft.size() - 1, 1) : draft.size();
        for (int i = 0; i < keep; i++)
          add_char(draft[i], (rec_no % 16 == 15) && i == 0);
        rec_no++;
      end
    end
    total_chars = chars_to_send.size();

    // Hold reset, then release at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every word accepted, every stamp returned, then let the pipe settle
    while (words_in < total_chars || stamps_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d characters incl. skipped CR/LF, noise and truncated records.",
             total_chars);
    $display("Checked %0d packed results: %0d in range, %0d rejected.",
             stamps_checked, stamps_valid, stamps_checked - stamps_valid);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/adpk_pkg.sv
rtl/core/adpk_front.sv
rtl/core/adpk_queue.sv
rtl/core/adpk_back.sv
rtl/core/ascii_datetime_to_dos_packed_unit.sv
tb/testbench.sv
